// ===== design/mrfrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfrs_pkg: shared types and constants for the meter reply record store
// Operation codes, command bytes, status codes, field selects and the
// classified item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package mrfrs_pkg;

  // operation field of an input item
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // reply frame command bytes
  localparam logic [7:0] CMD_COUNT = 8'h2B;
  localparam logic [7:0] CMD_DATE  = 8'h25;
  localparam logic [7:0] CMD_PRESS = 8'h26;
  localparam logic [7:0] CMD_CLEAR = 8'h52;

  // progress status codes
  localparam logic [2:0] ST_WAITING  = 3'd0;
  localparam logic [2:0] ST_COUNT    = 3'd1;
  localparam logic [2:0] ST_DATE     = 3'd2;
  localparam logic [2:0] ST_PRESSURE = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // field selects for a record read
  localparam logic [3:0] FLD_YEAR   = 4'd0;
  localparam logic [3:0] FLD_MONTH  = 4'd1;
  localparam logic [3:0] FLD_DAY    = 4'd2;
  localparam logic [3:0] FLD_HOUR   = 4'd3;
  localparam logic [3:0] FLD_MINUTE = 4'd4;
  localparam logic [3:0] FLD_IHB    = 4'd5;
  localparam logic [3:0] FLD_AVG    = 4'd6;
  localparam logic [3:0] FLD_SYS    = 4'd7;
  localparam logic [3:0] FLD_MAP    = 4'd8;
  localparam logic [3:0] FLD_DIA    = 4'd9;
  localparam logic [3:0] FLD_PULSE  = 4'd10;

  // front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int QAW     = $clog2(Q_DEPTH);

  // what the back end has to do with an item
  typedef enum logic [2:0] {
    K_NOP,    // good frame with unknown command, or unused operation
    K_BAD,    // checksum mismatch
    K_COUNT,
    K_DATE,
    K_PRESS,
    K_CLEAR,  // 0x52 frame
    K_READ,
    K_WAIT    // status clear operation
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [6:0] rec_idx;
    logic [3:0] fld_sel;
  } q_entry_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       ihb;
    logic       avg;
  } date_rec_t;

  typedef struct packed {
    logic [7:0] sys;
    logic [7:0] map;
    logic [7:0] dia;
    logic [7:0] pulse;
  } press_rec_t;

endpackage

// ===== design/mrfrs_in_if.sv =====
// ----------------------------------------------------------------------------
// mrfrs_in_if: input channel of the meter reply record store
// Valid/ready channel carrying one operation with its frame and read request.
// ----------------------------------------------------------------------------
interface mrfrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] frame_byte0;
  logic [7:0] frame_byte1;
  logic [7:0] frame_byte2;
  logic [7:0] frame_byte3;
  logic [7:0] frame_byte4;
  logic [7:0] frame_byte5;
  logic [7:0] frame_byte6;
  logic [7:0] frame_byte7;
  logic [6:0] record_index;
  logic [3:0] field_select;

  modport source (
    output valid, operation, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
           frame_byte4, frame_byte5, frame_byte6, frame_byte7, record_index,
           field_select,
    input  ready
  );

  modport sink (
    input  valid, operation, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
           frame_byte4, frame_byte5, frame_byte6, frame_byte7, record_index,
           field_select,
    output ready
  );
endinterface

// ===== design/mrfrs_out_if.sv =====
// ----------------------------------------------------------------------------
// mrfrs_out_if: result channel of the meter reply record store
// Valid/ready channel carrying one result item per input item.
// ----------------------------------------------------------------------------
interface mrfrs_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [2:0]  progress_status;
  logic [15:0] record_count;
  logic [7:0]  write_position;
  logic [7:0]  read_value;
  logic        write_dropped;

  modport source (
    output valid, frame_ok, progress_status, record_count, write_position,
           read_value, write_dropped,
    input  ready
  );

  modport sink (
    input  valid, frame_ok, progress_status, record_count, write_position,
           read_value, write_dropped,
    output ready
  );
endinterface

// ===== design/mrfrs_front.sv =====
// ----------------------------------------------------------------------------
// mrfrs_front: item intake and classification
// Checks the frame checksum, decodes operation and command into a kind and
// pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module mrfrs_front (
  mrfrs_in_if.sink            in_ch,
  input  logic                q_full,
  output logic                q_push,
  output mrfrs_pkg::q_entry_t q_entry
);
  import mrfrs_pkg::*;

  logic [7:0] sum;
  kind_t      kind;

  // low byte of bytes 0..6, wraps naturally at 8 bits
  assign sum = in_ch.frame_byte0 + in_ch.frame_byte1 + in_ch.frame_byte2 +
               in_ch.frame_byte3 + in_ch.frame_byte4 + in_ch.frame_byte5 +
               in_ch.frame_byte6;

  always_comb begin
    kind = K_NOP;
    case (in_ch.operation)
      OP_FRAME: begin
        if (sum != in_ch.frame_byte7) begin
          kind = K_BAD;
        end else begin
          case (in_ch.frame_byte1)
            CMD_COUNT: kind = K_COUNT;
            CMD_DATE:  kind = K_DATE;
            CMD_PRESS: kind = K_PRESS;
            CMD_CLEAR: kind = K_CLEAR;
            default:   kind = K_NOP;
          endcase
        end
      end
      OP_READ:  kind = K_READ;
      OP_CLEAR: kind = K_WAIT;
      default:  kind = K_NOP;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign q_entry.kind    = kind;
  assign q_entry.b2      = in_ch.frame_byte2;
  assign q_entry.b3      = in_ch.frame_byte3;
  assign q_entry.b4      = in_ch.frame_byte4;
  assign q_entry.b5      = in_ch.frame_byte5;
  assign q_entry.rec_idx = in_ch.record_index;
  assign q_entry.fld_sel = in_ch.field_select;

endmodule

// ===== design/mrfrs_queue.sv =====
// ----------------------------------------------------------------------------
// mrfrs_queue: short queue between front end and back end
// Two-entry FIFO of classified items.
// ----------------------------------------------------------------------------
module mrfrs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mrfrs_pkg::q_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output mrfrs_pkg::q_entry_t q_head
);
  import mrfrs_pkg::*;

  q_entry_t         mem_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic [QAW:0]     count_nxt;

  assign full    = (count_r == (QAW+1)'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(Q_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== design/mrfrs_back.sv =====
// ----------------------------------------------------------------------------
// mrfrs_back: item execution and record store
// Applies classified items to the index, count and status registers and the
// record memories, and drives the registered result channel.
// ----------------------------------------------------------------------------
module mrfrs_back #(
  parameter int RECORD_DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mrfrs_pkg::q_entry_t q_head,
  output logic                pop,
  mrfrs_out_if.source         out_ch
);
  import mrfrs_pkg::*;

  localparam int AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;

  typedef enum logic {
    S_EXEC,
    S_READ
  } state_t;

  state_t state_r;

  // architectural registers
  logic [7:0]  wp_r;
  logic [15:0] cnt_r;
  logic [2:0]  status_r;

  // result register
  logic        out_valid_r;
  logic        ok_r;
  logic [2:0]  st_out_r;
  logic [15:0] cnt_out_r;
  logic [7:0]  wp_out_r;
  logic [7:0]  rv_r;
  logic        drop_r;

  // pending read
  logic [3:0]  rd_sel_r;
  logic        rd_ok_r;

  // record memories, date half and pressure half
  date_rec_t   date_mem  [RECORD_DEPTH];
  press_rec_t  press_mem [RECORD_DEPTH];
  date_rec_t   date_q_r;
  press_rec_t  press_q_r;

  logic        take;
  logic        wr_in_range;
  logic        rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic        date_we;
  logic        press_we;
  logic        rd_en;
  logic [7:0]  wp_nxt;
  logic [15:0] cnt_nxt;
  logic [2:0]  status_nxt;
  logic        drop;
  date_rec_t   date_wd;
  press_rec_t  press_wd;
  logic [7:0]  rd_value;
  logic [15:0] date_word;

  assign take = out_valid_r && out_ch.ready;
  assign pop  = q_valid && (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign wr_in_range = 32'(wp_r) < RECORD_DEPTH;
  assign rd_in_range = 32'(q_head.rec_idx) < RECORD_DEPTH;
  assign wr_addr     = AW'(wp_r);
  assign rd_addr     = AW'(q_head.rec_idx);

  assign date_word      = {q_head.b3, q_head.b2};
  assign date_wd.year   = date_word[15:9];
  assign date_wd.month  = date_word[8:5];
  assign date_wd.day    = date_word[4:0];
  assign date_wd.hour   = q_head.b5[4:0];
  assign date_wd.minute = q_head.b4[5:0];
  assign date_wd.ihb    = q_head.b4[6];
  assign date_wd.avg    = q_head.b5[7];

  assign press_wd.sys   = q_head.b2;
  assign press_wd.map   = q_head.b3;
  assign press_wd.dia   = q_head.b4;
  assign press_wd.pulse = q_head.b5;

  always_comb begin
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    drop       = 1'b0;
    date_we    = 1'b0;
    press_we   = 1'b0;
    rd_en      = 1'b0;
    if (pop) begin
      case (q_head.kind)
        K_COUNT: begin
          wp_nxt     = '0;
          cnt_nxt    = {q_head.b3, q_head.b2};
          status_nxt = ST_COUNT;
        end
        K_DATE: begin
          date_we    = wr_in_range;
          drop       = !wr_in_range;
          status_nxt = ST_DATE;
        end
        K_PRESS: begin
          press_we   = wr_in_range;
          drop       = !wr_in_range;
          status_nxt = ST_PRESSURE;
          if (wr_in_range && (wp_r != 8'hFF)) begin
            wp_nxt = wp_r + 8'd1;
          end
        end
        K_CLEAR: status_nxt = ST_CLEARED;
        K_WAIT:  status_nxt = ST_WAITING;
        K_READ:  rd_en      = 1'b1;
        default: ;
      endcase
    end
  end

  // field mux on the registered memory word
  always_comb begin
    rd_value = '0;
    if (rd_ok_r) begin
      case (rd_sel_r)
        FLD_YEAR:   rd_value = 8'(date_q_r.year);
        FLD_MONTH:  rd_value = 8'(date_q_r.month);
        FLD_DAY:    rd_value = 8'(date_q_r.day);
        FLD_HOUR:   rd_value = 8'(date_q_r.hour);
        FLD_MINUTE: rd_value = 8'(date_q_r.minute);
        FLD_IHB:    rd_value = 8'(date_q_r.ihb);
        FLD_AVG:    rd_value = 8'(date_q_r.avg);
        FLD_SYS:    rd_value = press_q_r.sys;
        FLD_MAP:    rd_value = press_q_r.map;
        FLD_DIA:    rd_value = press_q_r.dia;
        FLD_PULSE:  rd_value = press_q_r.pulse;
        default:    rd_value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      cnt_r       <= '0;
      status_r    <= ST_WAITING;
    end else begin
      if (take) begin
        out_valid_r <= 1'b0;
      end
      wp_r     <= wp_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      case (state_r)
        S_EXEC: begin
          if (pop) begin
            if (q_head.kind == K_READ) begin
              state_r  <= S_READ;
              rd_sel_r <= q_head.fld_sel;
              rd_ok_r  <= rd_in_range;
            end else begin
              out_valid_r <= 1'b1;
              ok_r        <= (q_head.kind != K_BAD);
              st_out_r    <= status_nxt;
              cnt_out_r   <= cnt_nxt;
              wp_out_r    <= wp_nxt;
              rv_r        <= '0;
              drop_r      <= drop;
            end
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          ok_r        <= 1'b1;
          st_out_r    <= status_r;
          cnt_out_r   <= cnt_r;
          wp_out_r    <= wp_r;
          rv_r        <= rd_value;
          drop_r      <= 1'b0;
          state_r     <= S_EXEC;
        end
        default: state_r <= S_EXEC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (date_we) begin
      date_mem[wr_addr] <= date_wd;
    end
    if (press_we) begin
      press_mem[wr_addr] <= press_wd;
    end
    if (rd_en) begin
      date_q_r  <= date_mem[rd_addr];
      press_q_r <= press_mem[rd_addr];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_ok        = ok_r;
  assign out_ch.progress_status = st_out_r;
  assign out_ch.record_count    = cnt_out_r;
  assign out_ch.write_position  = wp_out_r;
  assign out_ch.read_value      = rv_r;
  assign out_ch.write_dropped   = drop_r;

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("result register busy during record read");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (q_head.kind == K_READ)) |=> (state_r == S_READ) && !pop)
    else $error("read did not enter its data cycle");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) <= RECORD_DEPTH)
    else $error("write index beyond store depth");

endmodule

// ===== design/meter_reply_frame_record_store.sv =====
// ----------------------------------------------------------------------------
// meter_reply_frame_record_store: reply frame record store, top level
// Front end, item queue and back end with the record memories.
// ----------------------------------------------------------------------------
// Takes 8-byte reply frames from a blood-pressure meter, plus record-read and
// status-clear operations, and returns exactly one result item per input item,
// in order. A frame whose low byte of the sum of bytes 0..6 differs from byte 7
// changes nothing and reports frame_ok = 0. Good frames dispatch on byte 1:
// 0x2B loads the record count and clears the write index, 0x25 writes date,
// time and flags at the write index, 0x26 writes systolic, MAP, diastolic and
// pulse there and advances the index, 0x52 only sets status; writes at or
// beyond RECORD_DEPTH are dropped and flagged. Frames and clears are executed
// in the back end's S_EXEC state; a read also passes through S_READ because
// the record memory read is registered before the field is selected, and no
// new item leaves the queue while a read is in S_READ. A two-item queue sits
// between intake and execution, so intake keeps taking items until the queue
// is full while the back end waits on a stalled result, and for a frame or
// clear the result register is refilled in the cycle its item leaves.
// Reading a record that was never written returns undefined data.
// ----------------------------------------------------------------------------
module meter_reply_frame_record_store #(
  parameter int RECORD_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  mrfrs_in_if.sink    in_ch,
  mrfrs_out_if.source out_ch
);
  import mrfrs_pkg::*;

  // front to queue
  logic     q_push;
  logic     q_full;
  q_entry_t q_entry;

  // queue to back
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  // checksum and command decode
  mrfrs_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // lets intake and execution stall independently
  mrfrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_head     (q_head)
  );

  // state update, record memories, result register
  mrfrs_back #(
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule
